// ===== sv/lgcw_pkg.sv =====
// ----------------------------------------------------------------------------
// lgcw_pkg: shared types and constants for the LCD glyph column writer
// Holds the channel payloads, the configuration register set, the job
// record passed from the front end to the back end, and the sequencer states.
// ----------------------------------------------------------------------------
package lgcw_pkg;

   // Input item actions.
   localparam logic ACT_GLYPH  = 1'b0;
   localparam logic ACT_CURSOR = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_ENABLE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_MASK        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASELINE_SHIFT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COMMAND_BASE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COMMAND_BASE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_PAGES       = 3'd6;

   // Header byte layout.
   localparam logic [7:0] HDR_RUN_MASK    = 8'h1F;
   localparam logic [7:0] HDR_HEIGHT_MASK = 8'hC0;

   // Offset added to a mirrored column address.
   localparam logic [7:0] MIRROR_OFFSET = 8'h60;

   // Depth of the queue between front and back end.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       action;
      logic [7:0] record_byte;
      logic [7:0] cursor_x;
      logic [7:0] cursor_y;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       inverse_enable;
      logic [7:0] inverse_mask;
      logic [3:0] baseline_shift;
      logic [7:0] page_command_base;
      logic [7:0] column_command_base;
      logic [7:0] display_width;
      logic [4:0] display_pages;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_CURSOR,
      JOB_GLYPH,
      JOB_BLANKS
   } job_kind_type;

   // One unit of work for the back end.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;      // glyph byte after shaping, or new cursor column
      logic [7:0]   row;       // new cursor row
      logic [4:0]   run;       // run length of the record
      logic [1:0]   height;    // record height minus one
      logic         end_row;   // glyph closes its page row
      logic         end_rec;   // glyph closes the record
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUR_HI,
      ST_CUR_LO,
      ST_CUR_PAGE,
      ST_REMAP_PAGE,
      ST_REMAP_HI,
      ST_REMAP_LO,
      ST_DATA,
      ST_ROW_PAGE,
      ST_ROW_HI,
      ST_ROW_LO
   } back_state_type;

endpackage

// ===== sv/lgcw_front.sv =====
// ----------------------------------------------------------------------------
// lgcw_front: record parser
// Tracks the position inside the glyph record, shapes glyph bytes and turns
// each input item into at most one job for the back end.
// ----------------------------------------------------------------------------
module lgcw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lgcw_pkg::req_type req_item,
   input  lgcw_pkg::cfg_type cfg,
   output logic             push,
   output lgcw_pkg::job_type job
);
   import lgcw_pkg::*;

   logic       expect_ff, expect_in;
   logic [4:0] run_ff, run_in;
   logic [4:0] bytes_ff, bytes_in;
   logic [2:0] pages_ff, pages_in;
   logic [1:0] height_ff, height_in;

   logic [4:0] bytes_dec;
   logic [2:0] pages_dec;
   logic [7:0] shifted;
   logic [7:0] glyph;
   logic [4:0] hdr_run;
   logic [1:0] hdr_height;

   always_comb begin
      shifted = cfg.baseline_shift[3] ? 8'h00 : (req_item.record_byte >> cfg.baseline_shift[2:0]);
      glyph   = cfg.inverse_enable ? (~shifted & cfg.inverse_mask) : shifted;
   end

   assign hdr_run    = 5'(req_item.record_byte & HDR_RUN_MASK);
   assign hdr_height = 2'((req_item.record_byte & HDR_HEIGHT_MASK) >> 6);
   assign bytes_dec  = bytes_ff - 5'd1;
   assign pages_dec  = pages_ff - 3'd1;

   always_comb begin
      expect_in = expect_ff;
      run_in    = run_ff;
      bytes_in  = bytes_ff;
      pages_in  = pages_ff;
      height_in = height_ff;
      push      = 1'b0;
      job       = '0;
      if (accept) begin
         if (req_item.action == ACT_CURSOR) begin
            // A cursor move drops any record in progress.
            push      = 1'b1;
            job.kind  = JOB_CURSOR;
            job.data  = req_item.cursor_x;
            job.row   = req_item.cursor_y;
            expect_in = 1'b1;
         end else if (expect_ff) begin
            run_in    = hdr_run;
            height_in = hdr_height;
            bytes_in  = hdr_run;
            pages_in  = {1'b0, hdr_height} + 3'd1;
            expect_in = 1'b0;
            if (hdr_run == 5'd0) begin
               // Empty record: only blank columns and row steps remain.
               push       = 1'b1;
               job.kind   = JOB_BLANKS;
               job.height = hdr_height;
               expect_in  = 1'b1;
            end
         end else begin
            push       = 1'b1;
            job.kind   = JOB_GLYPH;
            job.data   = glyph;
            job.run    = run_ff;
            job.height = height_ff;
            bytes_in   = bytes_dec;
            if (bytes_dec == 5'd0) begin
               job.end_row = 1'b1;
               pages_in    = pages_dec;
               if (pages_dec == 3'd0) begin
                  job.end_rec = 1'b1;
                  expect_in   = 1'b1;
               end else begin
                  bytes_in = run_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         run_ff    <= '0;
         bytes_ff  <= '0;
         pages_ff  <= '0;
         height_ff <= '0;
      end else begin
         expect_ff <= expect_in;
         run_ff    <= run_in;
         bytes_ff  <= bytes_in;
         pages_ff  <= pages_in;
         height_ff <= height_in;
      end
   end

endmodule

// ===== sv/lgcw_queue.sv =====
// ----------------------------------------------------------------------------
// lgcw_queue: job queue
// A small first-in first-out buffer that decouples the parser from the
// byte sequencer.
// ----------------------------------------------------------------------------
module lgcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lgcw_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output lgcw_pkg::job_type head_job
);
   import lgcw_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/lgcw_back.sv =====
// ----------------------------------------------------------------------------
// lgcw_back: byte sequencer
// Owns the display cursor and plays out each job as command and data bytes,
// one byte per cycle while rsp_stall is low, including high-column remap and row steps.
// ----------------------------------------------------------------------------
module lgcw_back (
   input  logic             clock,
   input  logic             reset,
   input  lgcw_pkg::cfg_type cfg,
   input  logic             wide_mode,
   input  logic             head_valid,
   input  lgcw_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lgcw_pkg::rsp_type rsp_item
);
   import lgcw_pkg::*;

   back_state_type state_ff, state_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] data_ff, data_in;
   logic       is_blank_ff, is_blank_in;
   logic [2:0] blanks_ff, blanks_in;
   logic       final_ff, final_in;
   logic [4:0] run_ff, run_in;
   logic [1:0] height_ff, height_in;

   logic       fire;
   logic       done;
   logic [2:0] blanks_dec;
   logic [7:0] blank_byte;
   logic [7:0] mirrored;
   logic [7:0] remap_row;

   assign fire       = (state_ff != ST_IDLE) && !rsp_stall;
   assign blanks_dec = blanks_ff - 3'd1;
   assign blank_byte = cfg.inverse_enable ? cfg.inverse_mask : 8'h00;
   assign mirrored   = (cfg.display_width - 8'd1) - col_ff + MIRROR_OFFSET;
   assign remap_row  = row_ff + {3'b000, cfg.display_pages};

   // Next state and cursor bookkeeping.
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      data_in     = data_ff;
      is_blank_in = is_blank_ff;
      blanks_in   = blanks_ff;
      final_in    = final_ff;
      run_in      = run_ff;
      height_in   = height_ff;
      done        = 1'b0;
      pop         = 1'b0;
      case (state_ff)
         ST_IDLE:       done = 1'b1;
         ST_CUR_HI:     if (fire) state_in = ST_CUR_LO;
         ST_CUR_LO:     if (fire) state_in = ST_CUR_PAGE;
         ST_CUR_PAGE:   if (fire) done = 1'b1;
         ST_REMAP_PAGE: if (fire) state_in = ST_REMAP_HI;
         ST_REMAP_HI:   if (fire) state_in = ST_REMAP_LO;
         ST_REMAP_LO:   if (fire) state_in = ST_DATA;
         ST_DATA: begin
            if (fire) begin
               col_in = col_ff + 8'd1;
               if (is_blank_ff) begin
                  blanks_in = blanks_dec;
                  if (blanks_dec != 3'd0 || !final_ff) begin
                     // Step one page down and back to the row start.
                     row_in = row_ff + 8'd1;
                     col_in = col_ff - {3'b000, run_ff};
                  end else begin
                     row_in = row_ff - {6'b000000, height_ff};
                  end
                  state_in = ST_ROW_PAGE;
               end else if (blanks_ff != 3'd0) begin
                  data_in     = blank_byte;
                  is_blank_in = 1'b1;
                  state_in    = (wide_mode && col_in[7]) ? ST_REMAP_PAGE : ST_DATA;
               end else begin
                  done = 1'b1;
               end
            end
         end
         ST_ROW_PAGE:   if (fire) state_in = ST_ROW_HI;
         ST_ROW_HI:     if (fire) state_in = ST_ROW_LO;
         ST_ROW_LO: begin
            if (fire) begin
               if (blanks_ff != 3'd0) begin
                  data_in     = blank_byte;
                  is_blank_in = 1'b1;
                  state_in    = (wide_mode && col_ff[7]) ? ST_REMAP_PAGE : ST_DATA;
               end else begin
                  done = 1'b1;
               end
            end
         end
         default:       state_in = ST_IDLE;
      endcase

      // The next job starts in the cycle the previous one hands over its final item.
      if (done) begin
         if (head_valid) begin
            pop       = 1'b1;
            run_in    = head_job.run;
            height_in = head_job.height;
            case (head_job.kind)
               JOB_CURSOR: begin
                  col_in   = head_job.data;
                  row_in   = head_job.row;
                  state_in = ST_CUR_HI;
               end
               JOB_GLYPH: begin
                  data_in     = head_job.data;
                  is_blank_in = 1'b0;
                  blanks_in   = {2'b00, head_job.end_row};
                  final_in    = head_job.end_rec;
                  state_in    = (wide_mode && col_in[7]) ? ST_REMAP_PAGE : ST_DATA;
               end
               JOB_BLANKS: begin
                  data_in     = blank_byte;
                  is_blank_in = 1'b1;
                  blanks_in   = {1'b0, head_job.height} + 3'd1;
                  final_in    = 1'b1;
                  state_in    = (wide_mode && col_in[7]) ? ST_REMAP_PAGE : ST_DATA;
               end
               default:    state_in = ST_IDLE;
            endcase
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   // Result bytes.
   always_comb begin
      rsp_valid         = (state_ff != ST_IDLE);
      rsp_item.spi_byte = 8'h00;
      rsp_item.is_data  = 1'b0;
      rsp_item.last     = 1'b0;
      case (state_ff)
         ST_CUR_HI, ST_ROW_HI: begin
            rsp_item.spi_byte = cfg.column_command_base | {4'h0, col_ff[7:4]};
         end
         ST_CUR_LO: begin
            rsp_item.spi_byte = {4'h0, col_ff[3:0]};
         end
         ST_ROW_LO: begin
            rsp_item.spi_byte = {4'h0, col_ff[3:0]};
            rsp_item.last     = (blanks_ff == 3'd0);
         end
         ST_CUR_PAGE: begin
            rsp_item.spi_byte = cfg.page_command_base | {4'h0, row_ff[3:0]};
            rsp_item.last     = 1'b1;
         end
         ST_ROW_PAGE: begin
            rsp_item.spi_byte = cfg.page_command_base | {4'h0, row_ff[3:0]};
         end
         ST_REMAP_PAGE: begin
            rsp_item.spi_byte = cfg.page_command_base | {4'h0, remap_row[3:0]};
         end
         ST_REMAP_HI: begin
            rsp_item.spi_byte = cfg.column_command_base | {4'h0, mirrored[7:4]};
         end
         ST_REMAP_LO: begin
            rsp_item.spi_byte = {4'h0, mirrored[3:0]};
         end
         ST_DATA: begin
            rsp_item.spi_byte = data_ff;
            rsp_item.is_data  = 1'b1;
            rsp_item.last     = !is_blank_ff && (blanks_ff == 3'd0);
         end
         default: begin
            rsp_item.spi_byte = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         col_ff      <= '0;
         row_ff      <= '0;
         is_blank_ff <= 1'b0;
         blanks_ff   <= '0;
         final_ff    <= 1'b0;
         run_ff      <= '0;
         height_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         is_blank_ff <= is_blank_in;
         blanks_ff   <= blanks_in;
         final_ff    <= final_in;
         run_ff      <= run_in;
         height_ff   <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== sv/lcd_glyph_column_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_glyph_column_writer: glyph record to display byte stream converter
// Parses glyph records and cursor moves and emits the command and data
// bytes for a page-addressed monochrome LCD controller.
// ----------------------------------------------------------------------------
// Path: with an empty queue and an idle sequencer, an accepted item's job is written into
//   the job queue, then loaded into the sequencer state that drives its first result byte.
// Throughput: the sequencer sends one byte per cycle while rsp_stall is low; a high-column
//   byte is preceded by remap commands, and a row end adds a blank byte and row-step commands.
//   The parser takes one item per cycle while the four-entry job queue has room.
// Reset: synchronous; restores the register defaults, homes the cursor, empties the queue.
// ----------------------------------------------------------------------------
module lcd_glyph_column_writer #(
   parameter int unsigned WIDE_THRESHOLD = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lgcw_pkg::req_type                    req_item,
   // Result items.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lgcw_pkg::rsp_type                    rsp_item,
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lgcw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                           csr_wdata
);
   import lgcw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    req_accept;
   logic    wide_mode;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_full;
   logic    q_head_valid;
   job_type q_head_job;

   // The register port never pushes back. Software must write registers only while the block
   // is idle; the block itself does not enforce this, so no write is held off here.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INVERSE_ENABLE:      cfg_in.inverse_enable      = csr_wdata[0];
            CSR_INVERSE_MASK:        cfg_in.inverse_mask        = csr_wdata;
            CSR_BASELINE_SHIFT:      cfg_in.baseline_shift      = csr_wdata[3:0];
            CSR_PAGE_COMMAND_BASE:   cfg_in.page_command_base   = csr_wdata;
            CSR_COLUMN_COMMAND_BASE: cfg_in.column_command_base = csr_wdata;
            CSR_DISPLAY_WIDTH:       cfg_in.display_width       = csr_wdata;
            CSR_DISPLAY_PAGES:       cfg_in.display_pages       = csr_wdata[4:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverse_enable      <= 1'b0;
         cfg_ff.inverse_mask        <= 8'd255;
         cfg_ff.baseline_shift      <= 4'd0;
         cfg_ff.page_command_base   <= 8'd176;
         cfg_ff.column_command_base <= 8'd16;
         cfg_ff.display_width       <= 8'd128;
         cfg_ff.display_pages       <= 5'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Columns at 128 and above are remapped only on displays wider than the threshold.
   assign wide_mode = (cfg_ff.display_width > 8'(WIDE_THRESHOLD));

   // The parser is held off only by a full queue, so a result waiting at the
   // output stops new items from coming in only once the queue has filled.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   lgcw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .push     (q_push),
      .job      (q_push_job)
   );

   lgcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   lgcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .wide_mode  (wide_mode),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // The parser never hands a job to a full queue.
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("job pushed into a full queue");

   // Every accepted cursor move produces a job.
   a_cursor_makes_job: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.action == ACT_CURSOR) |-> q_push)
      else $error("cursor move produced no job");

   // The sequencer comes out of reset with nothing to send.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A popped job always comes from a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("job taken from an empty queue");

endmodule
